@@ sv/api_frame_receiver_defines.svh @@
// Assertion macros shared by the frame receiver checker.
`ifndef API_FRAME_RECEIVER_DEFINES_SVH
`define API_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define AFR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/afr_pkg.sv @@
`default_nettype none

package afr_pkg;

   // Fixed widths of the word fields on the ports.
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 5;

   localparam logic [BYTE_W-1:0] START_DELIM = 8'h7E;
   localparam logic [BYTE_W-1:0] SUM_GOOD    = 8'hFF;

   typedef enum logic [5:0] {
      S_HUNT   = 6'b000001,
      S_LEN_HI = 6'b000010,
      S_LEN_LO = 6'b000100,
      S_DATA   = 6'b001000,
      S_SUM    = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

endpackage

`default_nettype wire

@@ sv/afr_frame_store.sv @@
`default_nettype none

// Frame data buffer: one write port and one read port with registered read data.
// The read data holds its value on cycles without a read.
module afr_frame_store #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [afr_pkg::BYTE_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [afr_pkg::BYTE_W-1:0] rd_data
);
   import afr_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/api_frame_receiver.sv @@
// API frame receiver. Each req word carries one byte from the serial link. Bytes are dropped
// until the start delimiter 0x7E arrives; the next two bytes give the frame length, high
// byte first. A length of zero or above BUFFER_BYTES-1 abandons the frame. The data bytes
// that follow are written into the frame buffer memory and summed modulo 256, and the byte
// after them is the checksum. When data plus checksum sum to 0xFF, the buffered bytes are
// sent out on rsp in order, each with its index, the frame length and a last-byte flag on
// the final one; otherwise the frame is dropped without a trace. A 0x7E inside a frame is
// an ordinary byte. Intake runs at one byte per clock. After a good checksum, intake pauses
// while the buffer is read out, one memory read per cycle while the pending stage is free
// or moves on, so the pause stretches while rsp_ready is held low. Reads feed a one-word
// pending stage and the rsp output register, so a new frame can start arriving while the last
// words of the previous one still wait to be taken.
`default_nettype none

module api_frame_receiver #(
   parameter int BUFFER_BYTES = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [afr_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic      [afr_pkg::BYTE_W-1:0] rsp_data_byte,
   output logic      [afr_pkg::IDX_W-1:0]  rsp_byte_index,
   output logic      [afr_pkg::IDX_W-1:0]  rsp_frame_length,
   output logic                            rsp_last_byte
);
   import afr_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam logic [BYTE_W-1:0] MaxLen = BYTE_W'(BUFFER_BYTES - 1);
   localparam logic [AW-1:0] One = AW'(1);

   // Frame parser state.
   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] len_hi_ff, len_hi_in;
   logic [AW-1:0]     len_ff, len_in;
   logic [AW-1:0]     wr_idx_ff, wr_idx_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [AW-1:0]     emit_idx_ff, emit_idx_in;

   // Pending stage: describes the word now sitting in the buffer's read register.
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_idx_ff, pend_idx_in;
   logic [AW-1:0]     pend_len_ff, pend_len_in;
   logic              pend_last_ff, pend_last_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [IDX_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_accept;
   logic [BYTE_W-1:0] sum_next;
   logic              wr_en;
   logic              rd_en;
   logic              load;
   logic [BYTE_W-1:0] rd_data;

   assign req_ready  = (state_ff != S_EMIT);
   assign req_accept = req_valid && req_ready;
   assign sum_next   = sum_ff + req_rx_byte;

   // The output register takes the pending word whenever it is empty or being emptied.
   assign load  = pend_ff && (!rsp_valid_ff || rsp_ready);
   // A new read may only start if the pending stage is free or moves on this cycle.
   assign rd_en = (state_ff == S_EMIT) && (!pend_ff || load);
   assign wr_en = (state_ff == S_DATA) && req_accept;

   always_comb begin
      state_in    = state_ff;
      len_hi_in   = len_hi_ff;
      len_in      = len_ff;
      wr_idx_in   = wr_idx_ff;
      sum_in      = sum_ff;
      emit_idx_in = emit_idx_ff;
      case (state_ff)
         S_HUNT: begin
            if (req_accept && req_rx_byte == START_DELIM) begin
               state_in = S_LEN_HI;
            end
         end
         S_LEN_HI: begin
            if (req_accept) begin
               len_hi_in = req_rx_byte;
               state_in  = S_LEN_LO;
            end
         end
         S_LEN_LO: begin
            if (req_accept) begin
               // Any nonzero high byte already exceeds the buffer.
               if (len_hi_ff != '0 || req_rx_byte == '0 || req_rx_byte > MaxLen) begin
                  state_in = S_HUNT;
               end else begin
                  len_in    = req_rx_byte[AW-1:0];
                  wr_idx_in = '0;
                  sum_in    = '0;
                  state_in  = S_DATA;
               end
            end
         end
         S_DATA: begin
            if (req_accept) begin
               sum_in    = sum_next;
               wr_idx_in = wr_idx_ff + One;
               if (wr_idx_ff == len_ff - One) begin
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            if (req_accept) begin
               emit_idx_in = '0;
               state_in    = (sum_next == SUM_GOOD) ? S_EMIT : S_HUNT;
            end
         end
         S_EMIT: begin
            if (rd_en) begin
               emit_idx_in = emit_idx_ff + One;
               if (emit_idx_ff == len_ff - One) begin
                  state_in = S_HUNT;
               end
            end
         end
         default: begin
            state_in = S_HUNT;
         end
      endcase
   end

   always_comb begin
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      pend_len_in  = pend_len_ff;
      pend_last_in = pend_last_ff;
      if (rd_en) begin
         pend_in      = 1'b1;
         pend_idx_in  = emit_idx_ff;
         pend_len_in  = len_ff;
         pend_last_in = (emit_idx_ff == len_ff - One);
      end else if (load) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rd_data;
         rsp_idx_in   = IDX_W'(pend_idx_ff);
         rsp_len_in   = IDX_W'(pend_len_ff);
         rsp_last_in  = pend_last_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_HUNT;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_hi_ff    <= len_hi_in;
      len_ff       <= len_in;
      wr_idx_ff    <= wr_idx_in;
      sum_ff       <= sum_in;
      emit_idx_ff  <= emit_idx_in;
      pend_idx_ff  <= pend_idx_in;
      pend_len_ff  <= pend_len_in;
      pend_last_ff <= pend_last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Writes happen only while a frame arrives and reads only while it is read out,
   // so the two ports never touch the same entry in one cycle.
   afr_frame_store #(
      .DEPTH (BUFFER_BYTES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (emit_idx_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_byte    = rsp_data_ff;
   assign rsp_byte_index   = rsp_idx_ff;
   assign rsp_frame_length = rsp_len_ff;
   assign rsp_last_byte    = rsp_last_ff;

endmodule

`default_nettype wire

@@ sv/api_frame_receiver_checker.sv @@
`default_nettype none
`include "api_frame_receiver_defines.svh"

module api_frame_receiver_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [afr_pkg::BYTE_W-1:0] rsp_data_byte,
   input wire logic [afr_pkg::IDX_W-1:0]  rsp_byte_index,
   input wire logic [afr_pkg::IDX_W-1:0]  rsp_frame_length,
   input wire logic                       rsp_last_byte
);
   import afr_pkg::*;

   // A stalled word keeps its payload.
   `AFR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_byte) && $stable(rsp_byte_index) && $stable(rsp_last_byte), "rsp word changed while stalled")

   // The last word of a frame sits at index frame_length - 1.
   `AFR_ASSERT_NOW(a_last_index, rsp_valid && rsp_last_byte, rsp_byte_index == IDX_W'(rsp_frame_length - IDX_W'(1)), "last word at wrong index")

   // Within a frame, the next word follows at once with the next index.
   `AFR_ASSERT_NEXT(a_next_index, rsp_valid && rsp_ready && !rsp_last_byte, rsp_valid && rsp_byte_index == IDX_W'($past(rsp_byte_index) + IDX_W'(1)), "frame words not contiguous")

   // Every word of one frame reports the same length.
   `AFR_ASSERT_NEXT(a_same_length, rsp_valid && rsp_ready && !rsp_last_byte, rsp_frame_length == $past(rsp_frame_length), "frame length changed inside a frame")

endmodule

bind api_frame_receiver api_frame_receiver_checker u_checker (.*);

`default_nettype wire
